@@ rtl/aes128_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 package
// Payload types, S-boxes and column-mixing functions.
// ----------------------------------------------------------------------------
package aes128_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int KEY_WORDS  = 4;
    localparam int NUM_RK     = 44;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_MODE = 3'd4;

    localparam logic [31:0] LANE_HI   = 32'h8080_8080;
    localparam logic [31:0] LANE_LO   = 32'h7f7f_7f7f;
    localparam logic [31:0] LANE_POLY = 32'h1b1b_1b1b;

    typedef struct packed {
        logic [31:0] block_word_three;
        logic [31:0] block_word_two;
        logic [31:0] block_word_one;
        logic [31:0] block_word_zero;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_word_three;
        logic [31:0] result_word_two;
        logic [31:0] result_word_one;
        logic [31:0] result_word_zero;
    } out_item_t;

    typedef logic [3:0][31:0] state_t;
    typedef logic [3:0][31:0] rkey_t;

    function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] lane_double(input logic [31:0] x);
        logic [31:0] hi;
        hi = x & LANE_HI;
        return ((x & LANE_LO) << 1) ^ ((hi - (hi >> 7)) & LANE_POLY);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] a);
        logic [31:0] d;
        d = lane_double(a);
        return d ^ rotl(d, 24) ^ rotl(a, 24) ^ rotl(a, 16) ^ rotl(a, 8);
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] a);
        logic [31:0] x2, x4, x8, x9, xb, xd, xe;
        x2 = lane_double(a);
        x4 = lane_double(x2);
        x8 = lane_double(x4);
        x9 = x8 ^ a;
        xb = x9 ^ x2;
        xd = x9 ^ x4;
        xe = x8 ^ x4 ^ x2;
        return xe ^ rotl(xd, 16) ^ rotl(x9, 8) ^ rotl(xb, 24);
    endfunction

endpackage

@@ rtl/aes128_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 round stage
// One registered round: SubBytes, ShiftRows, optional MixColumns, key add.
// ----------------------------------------------------------------------------
module aes128_round
    import aes128_pkg::*;
#(
    parameter bit LAST = 1'b0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  logic   valid_in,
    input  logic   decrypt_in,
    input  state_t state_in,
    input  rkey_t  rk_enc,
    input  rkey_t  rk_dec,
    output logic   valid_out,
    output logic   decrypt_out,
    output state_t state_out
);

    state_t sub, shf, mix, state_next;
    logic   valid_reg, decrypt_reg;
    state_t state_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                sub[c][8*b +: 8] = decrypt_in ? inv_sbox(state_in[c][8*b +: 8])
                                              : fwd_sbox(state_in[c][8*b +: 8]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                shf[c][8*r +: 8] = decrypt_in ? sub[(c + 3*r) % 4][8*r +: 8]
                                              : sub[(c + r) % 4][8*r +: 8];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            if (LAST)
                mix[c] = shf[c];
            else
                mix[c] = decrypt_in ? inv_mix_col(shf[c]) : mix_col(shf[c]);
            state_next[c] = mix[c] ^ (decrypt_in ? rk_dec[c] : rk_enc[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            decrypt_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg   <= valid_in;
            decrypt_reg <= decrypt_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            state_reg <= state_next;
    end

    assign valid_out   = valid_reg;
    assign decrypt_out = decrypt_reg;
    assign state_out   = state_reg;

endmodule

@@ rtl/aes128_block_cipher_unit.sv @@
`timescale 1ns / 1ps
// Pipeline: a registered key-add stage followed by 10 registered round stages.
// Throughput: one item per cycle; the pipeline advances whenever its output is free.
// Key schedule: each key word write re-expands the key, one round-key group per cycle
// while cfg_we is low; blocks must not enter until it completes.
// Reset clears pipeline valid bits, key and mode registers; round keys undefined.
// ----------------------------------------------------------------------------
// AES-128 block cipher unit
// Ten-round unrolled ECB pipeline with encrypt and equivalent-inverse decrypt.
// ----------------------------------------------------------------------------
module aes128_block_cipher_unit
    import aes128_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                                 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    logic [3:0][31:0] key_reg;
    logic             mode_reg;
    rkey_t            enc_rk_reg [NUM_ROUNDS + 1];
    rkey_t            dec_rk_reg [NUM_ROUNDS + 1];
    logic [3:0]       exp_cnt_reg, exp_cnt_next;
    logic             exp_busy_reg;
    rkey_t            prev_rk, new_rk;
    logic [31:0]      tw;

    // Key expansion: one round group per cycle while no config write is made.
    always_comb
    begin
        prev_rk = enc_rk_reg[exp_cnt_reg - 4'd1];
        tw = rotl(prev_rk[3], 24);
        tw = {fwd_sbox(tw[31:24]), fwd_sbox(tw[23:16]), fwd_sbox(tw[15:8]), fwd_sbox(tw[7:0])}
             ^ {24'd0, RCON[exp_cnt_reg - 4'd1]};
        new_rk[0] = prev_rk[0] ^ tw;
        new_rk[1] = prev_rk[1] ^ new_rk[0];
        new_rk[2] = prev_rk[2] ^ new_rk[1];
        new_rk[3] = prev_rk[3] ^ new_rk[2];
        exp_cnt_next = exp_cnt_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= '0;
            mode_reg     <= 1'b0;
            exp_busy_reg <= 1'b0;
            exp_cnt_reg  <= 4'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index) inside
                    REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
                    begin
                        key_reg[cfg_index[1:0]] <= cfg_data;
                        exp_busy_reg            <= 1'b1;
                        exp_cnt_reg             <= 4'd0;
                    end
                    REG_MODE: mode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            else if (exp_busy_reg)
            begin
                exp_cnt_reg <= exp_cnt_next;
                if (exp_cnt_reg == 4'(NUM_ROUNDS))
                    exp_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exp_busy_reg && !cfg_we)
        begin
            if (exp_cnt_reg == 4'd0)
            begin
                enc_rk_reg[0]          <= key_reg;
                dec_rk_reg[NUM_ROUNDS] <= key_reg;
            end
            else
            begin
                enc_rk_reg[exp_cnt_reg] <= new_rk;
                for (int i = 0; i < 4; i++)
                begin
                    if (exp_cnt_reg == 4'(NUM_ROUNDS))
                        dec_rk_reg[0][i] <= new_rk[i];
                    else
                        dec_rk_reg[4'(NUM_ROUNDS) - exp_cnt_reg][i] <= inv_mix_col(new_rk[i]);
                end
            end
        end
    end

    // Pipeline
    logic   advance;
    logic   v   [NUM_ROUNDS + 1];
    logic   dm  [NUM_ROUNDS + 1];
    state_t st  [NUM_ROUNDS + 1];
    logic   v0_reg, dm0_reg;
    state_t st0_reg;

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            dm0_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg  <= in_valid;
            dm0_reg <= mode_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st0_reg[0] <= in_item.block_word_zero  ^ (mode_reg ? dec_rk_reg[0][0] : enc_rk_reg[0][0]);
            st0_reg[1] <= in_item.block_word_one   ^ (mode_reg ? dec_rk_reg[0][1] : enc_rk_reg[0][1]);
            st0_reg[2] <= in_item.block_word_two   ^ (mode_reg ? dec_rk_reg[0][2] : enc_rk_reg[0][2]);
            st0_reg[3] <= in_item.block_word_three ^ (mode_reg ? dec_rk_reg[0][3] : enc_rk_reg[0][3]);
        end
    end

    assign v[0]  = v0_reg;
    assign dm[0] = dm0_reg;
    assign st[0] = st0_reg;

    for (genvar r = 1; r <= NUM_ROUNDS; r++)
    begin : g_round
        aes128_round #(.LAST(r == NUM_ROUNDS)) u_round (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .valid_in    (v[r-1]),
            .decrypt_in  (dm[r-1]),
            .state_in    (st[r-1]),
            .rk_enc      (enc_rk_reg[r]),
            .rk_dec      (dec_rk_reg[r]),
            .valid_out   (v[r]),
            .decrypt_out (dm[r]),
            .state_out   (st[r])
        );
    end

    assign out_valid                   = v[NUM_ROUNDS];
    assign out_item.result_word_zero   = st[NUM_ROUNDS][0];
    assign out_item.result_word_one    = st[NUM_ROUNDS][1];
    assign out_item.result_word_two    = st[NUM_ROUNDS][2];
    assign out_item.result_word_three  = st[NUM_ROUNDS][3];

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed under stall");
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_exp_count: assert property (@(posedge clk) disable iff (!rst_n)
        exp_busy_reg |-> exp_cnt_reg <= 4'(NUM_ROUNDS))
        else $error("expansion counter overrun");
`endif

endmodule

@@ tb/aes128_block_cipher_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher unit testbench
// Drives keys, mode and blocks through the unit with random idling on both
// sides and checks every result block against a local cipher model.
// ----------------------------------------------------------------------------
module aes128_block_cipher_unit_test;
    import aes128_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;

    aes128_block_cipher_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    localparam int SETTLE_CYCLES = 40;
    localparam logic [2:0] REG_UNUSED = 3'd6;

    logic [7:0]  sbox_f [256];
    logic [7:0]  sbox_i [256];
    logic [31:0] key_words [4];
    logic        decrypt_on;
    logic [31:0] enc_keys [44];
    logic [31:0] dec_keys [44];
    out_item_t   pending_blocks [$];
    int          error_count;
    int          hold_cycles;
    bit          idle_out;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [31:0] rot_left(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] xtime4(logic [31:0] x);
        logic [31:0] hi;
        hi = x & 32'h8080_8080;
        return ((x & 32'h7f7f_7f7f) << 1) ^ ((hi - (hi >> 7)) & 32'h1b1b_1b1b);
    endfunction

    function automatic logic [31:0] mix_word(logic [31:0] a);
        logic [31:0] d;
        d = xtime4(a);
        return d ^ rot_left(d, 24) ^ rot_left(a, 24) ^ rot_left(a, 16) ^ rot_left(a, 8);
    endfunction

    function automatic logic [31:0] unmix_word(logic [31:0] a);
        logic [31:0] x2, x4, x8, x9, xb, xd, xe;
        x2 = xtime4(a);
        x4 = xtime4(x2);
        x8 = xtime4(x4);
        x9 = x8 ^ a;
        xb = x9 ^ x2;
        xd = x9 ^ x4;
        xe = x8 ^ x4 ^ x2;
        return xe ^ rot_left(xd, 16) ^ rot_left(x9, 8) ^ rot_left(xb, 24);
    endfunction

    function automatic logic [31:0] subst_word(logic [31:0] w, bit inv);
        logic [31:0] r;
        for (int b = 0; b < 4; b++)
            r[8*b +: 8] = inv ? sbox_i[w[8*b +: 8]] : sbox_f[w[8*b +: 8]];
        return r;
    endfunction

    // sbox built from GF(2^8) inverse plus affine map
    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    task automatic build_sboxes();
        logic [7:0] inv, s;
        for (int x = 0; x < 256; x++)
        begin
            inv = 0;
            for (int y = 1; y < 256; y++)
                if (gmul(x, y) == 8'h01)
                    inv = y;
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox_f[x] = s;
            sbox_i[s] = x;
        end
    endtask

    task automatic expand_schedule();
        logic [31:0] w;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
            enc_keys[i] = key_words[i];
        for (int i = 4; i < 44; i++)
        begin
            w = enc_keys[i-1];
            if (i % 4 == 0)
            begin
                w = subst_word(rot_left(w, 24), 1'b0) ^ {24'h0, rc};
                rc = gmul(rc, 8'h02);
            end
            enc_keys[i] = enc_keys[i-4] ^ w;
        end
        for (int r = 0; r <= 10; r++)
            for (int i = 0; i < 4; i++)
                dec_keys[r*4+i] = (r == 0 || r == 10) ? enc_keys[(10-r)*4+i]
                                                     : unmix_word(enc_keys[(10-r)*4+i]);
    endtask

    function automatic out_item_t cipher_block(in_item_t blk);
        logic [31:0] s [4];
        logic [31:0] t [4];
        logic [31:0] ks [44];
        out_item_t   res;
        int          dir;
        ks = decrypt_on ? dec_keys : enc_keys;
        dir = decrypt_on ? 3 : 1;
        s[0] = blk.block_word_zero ^ ks[0];
        s[1] = blk.block_word_one ^ ks[1];
        s[2] = blk.block_word_two ^ ks[2];
        s[3] = blk.block_word_three ^ ks[3];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                s[c] = subst_word(s[c], decrypt_on);
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    t[c][8*row +: 8] = s[(c + dir*row) % 4][8*row +: 8];
            for (int c = 0; c < 4; c++)
            begin
                if (r != 10)
                    t[c] = decrypt_on ? unmix_word(t[c]) : mix_word(t[c]);
                s[c] = t[c] ^ ks[r*4+c];
            end
        end
        res.result_word_zero  = s[0];
        res.result_word_one   = s[1];
        res.result_word_two   = s[2];
        res.result_word_three = s[3];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %08h want %08h", what, got, want);
        error_count++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_MODE)
            decrypt_on = val[0];
        else if (idx <= REG_KEY3)
        begin
            key_words[idx] = val;
            expand_schedule();
        end
    endtask

    // called at a falling edge
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_key(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                            logic [31:0] k3, bit dec);
        wait_idle();
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_MODE, {31'h0, dec});
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_block(in_item_t blk, bit gaps);
        int gap;
        gap = 0;
        if (gaps)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= blk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_blocks.push_back(cipher_block(blk));
        @(negedge clk);
    endtask

    function automatic in_item_t rand_block();
        in_item_t b;
        b = {$urandom, $urandom, $urandom, $urandom};
        return b;
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_blocks.size() == 0)
            begin
                report_mismatch("unexpected word0", out_item.result_word_zero, '0);
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (out_item.result_word_zero !== want.result_word_zero)
                    report_mismatch("word0", out_item.result_word_zero, want.result_word_zero);
                if (out_item.result_word_one !== want.result_word_one)
                    report_mismatch("word1", out_item.result_word_one, want.result_word_one);
                if (out_item.result_word_two !== want.result_word_two)
                    report_mismatch("word2", out_item.result_word_two, want.result_word_two);
                if (out_item.result_word_three !== want.result_word_three)
                    report_mismatch("word3", out_item.result_word_three,
                                    want.result_word_three);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ready <= 1'b0;
        end
        else if (idle_out)
        begin
            if ($urandom_range(0, 40) == 0)
            begin
                hold_cycles = $urandom_range(5, 30);
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic test_known_vectors();
        in_item_t b;
        // FIPS-197 appendix C.1 key and plaintext
        load_key(32'h0302_0100, 32'h0706_0504, 32'h0b0a_0908, 32'h0f0e_0d0c, 1'b0);
        b = {32'hffee_ddcc, 32'hbbaa_9988, 32'h7766_5544, 32'h3322_1100};
        send_block(b, 1'b0);
        load_key(32'h0302_0100, 32'h0706_0504, 32'h0b0a_0908, 32'h0f0e_0d0c, 1'b1);
        b = {32'h5ac5_b470, 32'h80b7_cdd8, 32'h3004_7b6a, 32'hd8e0_c469};
        send_block(b, 1'b0);
    endtask

    task automatic test_extremes();
        for (int d = 0; d < 2; d++)
        begin
            load_key('0, '0, '0, '0, d);
            send_block('0, 1'b0);
            send_block('1, 1'b0);
            send_block({4{32'h8080_8080}}, 1'b0);
            load_key('1, '1, '1, '1, d);
            send_block('0, 1'b0);
            send_block('1, 1'b0);
            send_block({4{32'h7f7f_7f7f}}, 1'b0);
        end
    endtask

    task automatic test_partial_key();
        load_key(32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444, 1'b0);
        wait_idle();
        write_reg(REG_KEY2, 32'hdead_beef);
        repeat (SETTLE_CYCLES) @(negedge clk);
        send_block(rand_block(), 1'b0);
        wait_idle();
        write_reg(REG_UNUSED, 32'hffff_ffff);
        write_reg(REG_MODE, 32'hffff_fffe);
        repeat (SETTLE_CYCLES) @(negedge clk);
        send_block(rand_block(), 1'b0);
        send_block(rand_block(), 1'b0);
    endtask

    task automatic test_backpressure();
        load_key($urandom, $urandom, $urandom, $urandom, 1'b1);
        idle_out = 1'b0;
        hold_cycles = 60;
        for (int i = 0; i < 40; i++)
            send_block(rand_block(), 1'b0);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 14; phase++)
        begin
            load_key($urandom, $urandom, $urandom, $urandom, phase[0]);
            idle_out = (phase % 4) != 3;
            for (int i = 0; i < 100; i++)
                send_block(rand_block(), idle_out);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_item     = '0;
        out_ready   = 1'b0;
        error_count = 0;
        hold_cycles = 0;
        idle_out    = 1'b0;
        decrypt_on  = 1'b0;
        for (int i = 0; i < 4; i++)
            key_words[i] = '0;
        build_sboxes();
        expand_schedule();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_known_vectors();
        test_extremes();
        test_partial_key();
        test_backpressure();
        test_random();
        idle_out = 1'b0;
        wait_idle();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
